// ===== design/bpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared types, constants and the prefix compare of the barcode prefix
// demultiplexer.
// ----------------------------------------------------------------------------
package bpd_pkg;

  localparam int NUM_ENTRIES = 64;
  localparam int MAX_BASES   = 16;

  localparam int BaseW   = 3;
  localparam int CodeW   = 48;
  localparam int LenInW  = 5;
  localparam int LenW    = $clog2(MAX_BASES + 1);
  localparam int EntryW  = 6;
  localparam int BinW    = 7;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 7;

  // Clock edges from the accepting edge to the edge that takes the result.
  localparam int Latency = NUM_ENTRIES + 2;

  typedef enum logic {
    MODE_CLASSIFY = 1'b0,
    MODE_LOAD     = 1'b1
  } item_mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DUAL_INDEX     = 2'd0,
    CFG_KEEP_UNMATCHED = 2'd1,
    CFG_ENTRY_COUNT    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    item_mode_e             mode;
    logic [EntryW-1:0]      entry;
    logic [CodeW-1:0]       first_code;
    logic [LenW-1:0]        first_len;
    logic [CodeW-1:0]       second_code;
    logic [LenW-1:0]        second_len;
    logic                   hit;
    logic [BinW-1:0]        bin;
  } stage_t;

  function automatic logic [LenW-1:0] sat_len(input logic [LenInW-1:0] len);
    logic [LenW-1:0] res;
    if (len > LenInW'(MAX_BASES)) begin
      res = LenW'(MAX_BASES);
    end else begin
      res = len[LenW-1:0];
    end
    return res;
  endfunction

  function automatic logic prefix_match(input logic [CodeW-1:0] bc,
                                        input logic [LenW-1:0]  bc_len,
                                        input logic [CodeW-1:0] rd,
                                        input logic [LenW-1:0]  rd_len);
    logic ok;
    ok = (rd_len >= bc_len);
    for (int b = 0; b < MAX_BASES; b++) begin
      if ((LenW'(b) < bc_len) && (bc[BaseW*b +: BaseW] != rd[BaseW*b +: BaseW])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// ===== design/bpd_cell.sv =====
// ----------------------------------------------------------------------------
// bpd_cell
// One barcode entry of the chain. Load items that pass store the entry when
// the index matches; classify items that pass are compared against it and
// take this cell's index as bin on the first hit.
// ----------------------------------------------------------------------------
module bpd_cell
  import bpd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [BinW-1:0] cell_idx_i,
  input  logic            active_i,
  input  logic            dual_i,
  input  logic            valid_i,
  input  stage_t          stage_i,
  output logic            valid_o,
  output stage_t          stage_o
);

  logic [CodeW-1:0] first_code_q;
  logic [LenW-1:0]  first_len_q;
  logic [CodeW-1:0] second_code_q;
  logic [LenW-1:0]  second_len_q;
  logic             valid_q;
  stage_t           stage_q;
  stage_t           stage_d;
  logic             wr_sel;
  logic             entry_hit;

  assign wr_sel = valid_i && (stage_i.mode == MODE_LOAD) &&
                  (BinW'(stage_i.entry) == cell_idx_i);

  assign entry_hit = active_i &&
    prefix_match(first_code_q, first_len_q, stage_i.first_code, stage_i.first_len) &&
    (!dual_i ||
     prefix_match(second_code_q, second_len_q, stage_i.second_code, stage_i.second_len));

  always_comb begin
    stage_d = stage_i;
    if ((stage_i.mode == MODE_CLASSIFY) && !stage_i.hit && entry_hit) begin
      stage_d.hit = 1'b1;
      stage_d.bin = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      first_code_q  <= stage_i.first_code;
      first_len_q   <= stage_i.first_len;
      second_code_q <= stage_i.second_code;
      second_len_q  <= stage_i.second_len;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

  // A hit never comes from a cell outside the entries in use.
  a_hit_only_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && stage_d.hit && !stage_i.hit |-> active_i)
    else $error("hit taken by an inactive cell");

  // Once a bin is taken it travels on unchanged.
  a_hit_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && stage_i.hit |=> stage_q.hit && (stage_q.bin == $past(stage_i.bin)))
    else $error("earlier hit overwritten");

  // A load item never gains a hit.
  a_load_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (stage_i.mode == MODE_LOAD) |-> (stage_d.hit == stage_i.hit))
    else $error("load item marked as hit");

endmodule

// ===== design/barcode_prefix_demultiplexer.sv =====
// ----------------------------------------------------------------------------
// barcode_prefix_demultiplexer
// Classifies index reads against a table of barcode entries held in a chain
// of cells, one entry per cell; load items travel the same chain and write
// the addressed cell, so every item sees the table in transfer order.
// ----------------------------------------------------------------------------
// An item enters through an input register, passes one cell per entry along
// the chain and leaves through an output register to the result transfer.
// Throughput: one item per cycle; busy stays low.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset clears the pipeline and the dual-index and entry-count registers and
// sets keep-unmatched; table entries are undefined until written.
module barcode_prefix_demultiplexer
  import bpd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               mode_i,
  input  logic [EntryW-1:0]  entry_i,
  input  logic [CodeW-1:0]   first_code_i,
  input  logic [LenInW-1:0]  first_length_i,
  input  logic [CodeW-1:0]   second_code_i,
  input  logic [LenInW-1:0]  second_length_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output logic               done_o,
  output logic [BinW-1:0]    bin_o,
  output logic               matched_o,
  output logic               dropped_o
);

  logic            dual_q;
  logic            keep_q;
  logic [BinW-1:0] entry_count_q;
  logic [BinW-1:0] count;
  logic            accept;

  logic            chain_valid [NUM_ENTRIES+1];
  stage_t          chain       [NUM_ENTRIES+1];
  logic            in_valid_q;
  stage_t          in_stage_q;
  stage_t          in_stage_d;

  logic            done_q;
  logic [BinW-1:0] bin_q;
  logic [BinW-1:0] bin_d;
  logic            matched_q;
  logic            dropped_q;
  logic            dropped_d;
  stage_t          last;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dual_q        <= 1'b0;
      keep_q        <= 1'b1;
      entry_count_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_DUAL_INDEX:     dual_q        <= cfg_data_i[0];
        CFG_KEEP_UNMATCHED: keep_q        <= cfg_data_i[0];
        CFG_ENTRY_COUNT:    entry_count_q <= cfg_data_i[BinW-1:0];
        default: ;
      endcase
    end
  end

  assign count = (entry_count_q > BinW'(NUM_ENTRIES)) ? BinW'(NUM_ENTRIES) : entry_count_q;

  always_comb begin
    in_stage_d             = '0;
    in_stage_d.mode        = item_mode_e'(mode_i);
    in_stage_d.entry       = entry_i;
    in_stage_d.first_code  = first_code_i;
    in_stage_d.first_len   = sat_len(first_length_i);
    in_stage_d.second_code = second_code_i;
    in_stage_d.second_len  = sat_len(second_length_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    in_stage_q <= in_stage_d;
  end

  assign chain_valid[0] = in_valid_q;
  assign chain[0]       = in_stage_q;

  for (genvar k = 0; k < NUM_ENTRIES; k++) begin : g_cell
    bpd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (BinW'(k)),
      .active_i   (BinW'(k) < count),
      .dual_i     (dual_q),
      .valid_i    (chain_valid[k]),
      .stage_i    (chain[k]),
      .valid_o    (chain_valid[k+1]),
      .stage_o    (chain[k+1])
    );
  end

  assign last = chain[NUM_ENTRIES];

  always_comb begin
    bin_d     = last.bin;
    dropped_d = 1'b0;
    if (!last.hit) begin
      if (keep_q) begin
        bin_d = count;
      end else begin
        bin_d     = '0;
        dropped_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= chain_valid[NUM_ENTRIES] && (last.mode == MODE_CLASSIFY);
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q     <= bin_d;
    matched_q <= last.hit;
    dropped_q <= dropped_d;
  end

  assign done_o    = done_q;
  assign bin_o     = bin_q;
  assign matched_o = matched_q;
  assign dropped_o = dropped_q;

  a_classify_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i == MODE_CLASSIFY) |-> ##Latency done_o)
    else $error("classify item without result");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (mode_i == MODE_LOAD) |-> ##Latency !done_o)
    else $error("load item produced a result");

  a_drop_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && dropped_o |-> !matched_o && (bin_o == '0) && !keep_q)
    else $error("dropped result with bin or match set");

  a_match_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && matched_o |-> (bin_o < count) && !dropped_o)
    else $error("matched bin outside the entries in use");

endmodule

// ===== tb/sv/barcode_prefix_demultiplexer_tb.sv =====
// ----------------------------------------------------------------------------
// barcode_prefix_demultiplexer_tb
// Self-checking testbench for the barcode prefix demultiplexer. A directed
// table covers the reset state, the field extremes, long lengths, drop and
// other-bin outcomes. Random phases then reprogram the registers while the
// block is idle, fill the barcode table and send reads, most of them built
// from table entries. Each result is checked against the predictor or the row's expected value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module barcode_prefix_demultiplexer_tb;
  import bpd_pkg::*;

  localparam int ItemTarget = 1550;

  typedef struct packed {
    item_mode_e          mode;
    logic [EntryW-1:0]   entry;
    logic [CodeW-1:0]    first_code;
    logic [LenInW-1:0]   first_len;
    logic [CodeW-1:0]    second_code;
    logic [LenInW-1:0]   second_len;
  } read_item_t;

  typedef struct packed {
    logic [BinW-1:0] bin;
    logic            matched;
    logic            dropped;
  } bin_result_t;

  typedef enum logic {
    ROW_ITEM     = 1'b0,
    ROW_SETTINGS = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    read_item_t       item;
    logic             dual;
    logic             keep;
    logic [CfgW-1:0]  count;
    logic             has_exp;
    bin_result_t      exp;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               mode_i;
  logic [EntryW-1:0]  entry_i;
  logic [CodeW-1:0]   first_code_i;
  logic [LenInW-1:0]  first_length_i;
  logic [CodeW-1:0]   second_code_i;
  logic [LenInW-1:0]  second_length_i;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;
  logic               done_o;
  logic [BinW-1:0]    bin_o;
  logic               matched_o;
  logic               dropped_o;

  logic [CodeW-1:0] tbl_first_code [NUM_ENTRIES];
  logic [CodeW-1:0] tbl_second_code[NUM_ENTRIES];
  int unsigned      tbl_first_len  [NUM_ENTRIES];
  int unsigned      tbl_second_len [NUM_ENTRIES];
  bit               tbl_written    [NUM_ENTRIES];

  logic        cur_dual  = 1'b0;
  logic        cur_keep  = 1'b1;
  int unsigned cur_count = 0;

  bin_result_t pending_bins[$];
  stim_row_t   stim_table[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          burst_left = 0;

  barcode_prefix_demultiplexer u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .entry_i        (entry_i),
    .first_code_i   (first_code_i),
    .first_length_i (first_length_i),
    .second_code_i  (second_code_i),
    .second_length_i(second_length_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .bin_o          (bin_o),
    .matched_o      (matched_o),
    .dropped_o      (dropped_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic int unsigned clamp_len(input logic [LenInW-1:0] len);
    return (len > MAX_BASES) ? MAX_BASES : int'(len);
  endfunction

  function automatic logic [CodeW-1:0] bases_mask(input int unsigned n);
    return (n == 0) ? '0 : ({CodeW{1'b1}} >> (CodeW - BaseW * n));
  endfunction

  function automatic logic barcode_covers(input logic [CodeW-1:0] bc,
                                          input int unsigned      bc_len,
                                          input logic [CodeW-1:0] rd,
                                          input int unsigned      rd_len);
    return (rd_len >= bc_len) && (((bc ^ rd) & bases_mask(bc_len)) == '0);
  endfunction

  function automatic bin_result_t classify_read(input read_item_t it);
    bin_result_t res;
    int unsigned span;
    int unsigned l1;
    int unsigned l2;
    span = (cur_count > NUM_ENTRIES) ? NUM_ENTRIES : cur_count;
    l1 = clamp_len(it.first_len);
    l2 = clamp_len(it.second_len);
    res = '0;
    for (int k = 0; k < span; k++) begin
      if (barcode_covers(tbl_first_code[k], tbl_first_len[k], it.first_code, l1) &&
          (!cur_dual ||
           barcode_covers(tbl_second_code[k], tbl_second_len[k], it.second_code, l2))) begin
        res.bin = BinW'(k);
        res.matched = 1'b1;
        return res;
      end
    end
    if (cur_keep) begin
      res.bin = BinW'(span);
    end else begin
      res.dropped = 1'b1;
    end
    return res;
  endfunction

  function automatic logic [CodeW-1:0] rand_code();
    return CodeW'({$urandom, $urandom});
  endfunction

  function automatic logic [LenInW-1:0] rand_barcode_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return LenInW'($urandom_range(17, 31));
    end else if (r == 2) begin
      return LenInW'(MAX_BASES);
    end
    return LenInW'($urandom_range(1, 6));
  endfunction

  function automatic read_item_t random_load(input int unsigned idx);
    read_item_t it;
    it.mode        = MODE_LOAD;
    it.entry       = EntryW'(idx);
    it.first_code  = rand_code();
    it.first_len   = rand_barcode_len();
    it.second_code = rand_code();
    it.second_len  = rand_barcode_len();
    return it;
  endfunction

  function automatic read_item_t random_read();
    read_item_t it;
    it.mode        = MODE_CLASSIFY;
    it.entry       = EntryW'($urandom);
    it.first_code  = rand_code();
    it.first_len   = $urandom_range(0, 1) ? LenInW'(MAX_BASES) : LenInW'($urandom_range(0, 31));
    it.second_code = rand_code();
    it.second_len  = $urandom_range(0, 1) ? LenInW'(MAX_BASES) : LenInW'($urandom_range(0, 31));
    return it;
  endfunction

  // Builds an index read that carries the barcode as its prefix, now and then
  // with one base changed or with a random length.
  function automatic void follow_barcode(input  logic [CodeW-1:0]  bc,
                                         input  int unsigned       bc_len,
                                         output logic [CodeW-1:0]  code,
                                         output logic [LenInW-1:0] len);
    logic [CodeW-1:0] mask;
    int unsigned      b;
    mask = bases_mask(bc_len);
    code = (rand_code() & ~mask) | (bc & mask);
    if (bc_len > 0 && $urandom_range(0, 4) == 0) begin
      b = $urandom_range(0, bc_len - 1);
      code[BaseW*b +: BaseW] = code[BaseW*b +: BaseW] ^ BaseW'($urandom_range(1, 7));
    end
    if ($urandom_range(0, 5) == 0) begin
      len = LenInW'($urandom_range(0, 31));
    end else begin
      len = LenInW'($urandom_range(bc_len, MAX_BASES));
    end
  endfunction

  function automatic read_item_t read_near(input int unsigned k);
    read_item_t       it;
    logic [CodeW-1:0]  code;
    logic [LenInW-1:0] len;
    it = random_read();
    follow_barcode(tbl_first_code[k], tbl_first_len[k], code, len);
    it.first_code = code;
    it.first_len  = len;
    follow_barcode(tbl_second_code[k], tbl_second_len[k], code, len);
    it.second_code = code;
    it.second_len  = len;
    return it;
  endfunction

  function automatic stim_row_t load_row(input int unsigned idx,
                                         input logic [CodeW-1:0] c1, input int unsigned l1,
                                         input logic [CodeW-1:0] c2, input int unsigned l2);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item = '{MODE_LOAD, EntryW'(idx), c1, LenInW'(l1), c2, LenInW'(l2)};
    return row;
  endfunction

  function automatic stim_row_t read_row(input logic [CodeW-1:0] c1, input int unsigned l1,
                                         input logic [CodeW-1:0] c2, input int unsigned l2);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item = '{MODE_CLASSIFY, '0, c1, LenInW'(l1), c2, LenInW'(l2)};
    return row;
  endfunction

  function automatic stim_row_t read_row_exp(input logic [CodeW-1:0] c1, input int unsigned l1,
                                             input logic [CodeW-1:0] c2, input int unsigned l2,
                                             input int unsigned bin, input logic matched,
                                             input logic dropped);
    stim_row_t row;
    row = read_row(c1, l1, c2, l2);
    row.has_exp = 1'b1;
    row.exp = '{BinW'(bin), matched, dropped};
    return row;
  endfunction

  function automatic stim_row_t settings_row(input logic dual, input logic keep,
                                             input int unsigned count);
    stim_row_t row;
    row = '0;
    row.kind  = ROW_SETTINGS;
    row.dual  = dual;
    row.keep  = keep;
    row.count = CfgW'(count);
    return row;
  endfunction

  task automatic drive_item(input read_item_t it, input logic has_exp,
                            input bin_result_t exp);
    start           <= 1'b1;
    mode_i          <= it.mode;
    entry_i         <= it.entry;
    first_code_i    <= it.first_code;
    first_length_i  <= it.first_len;
    second_code_i   <= it.second_code;
    second_length_i <= it.second_len;
    do @(posedge clk_i); while (busy);
    if (it.mode == MODE_LOAD) begin
      tbl_first_code[it.entry]  = it.first_code;
      tbl_first_len[it.entry]   = clamp_len(it.first_len);
      tbl_second_code[it.entry] = it.second_code;
      tbl_second_len[it.entry]  = clamp_len(it.second_len);
      tbl_written[it.entry]     = 1'b1;
    end else begin
      pending_bins.push_back(has_exp ? exp : classify_read(it));
    end
    items_sent++;
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3))
        @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 30);
    end
  endtask

  // Registers change only once the pipeline is empty; a load leaves no result
  // behind, so a full latency is allowed after the last result.
  task automatic apply_settings(input logic dual, input logic keep,
                                input logic [CfgW-1:0] count);
    cfg_reg_e        regs[3] = '{CFG_DUAL_INDEX, CFG_KEEP_UNMATCHED, CFG_ENTRY_COUNT};
    logic [CfgW-1:0] vals[3];
    vals[0] = {(CfgW-1)'($urandom_range(0, 63)), dual};
    vals[1] = {(CfgW-1)'($urandom_range(0, 63)), keep};
    vals[2] = count;
    start <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
    for (int r = 0; r < 3; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[r];
      cfg_data_i  <= vals[r];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    cur_dual  = dual;
    cur_keep  = keep;
    cur_count = 32'(count);
  endtask

  always @(posedge clk_i) begin : result_check
    bin_result_t want;
    if (rst_ni && done_o) begin
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual bin %0d matched %0b dropped %0b",
                 $realtime, bin_o, matched_o, dropped_o);
        mismatch_count++;
      end else begin
        want = pending_bins.pop_front();
        if (bin_o !== want.bin) begin
          $display("%0t: bin mismatch, expected %0d, actual %0d", $realtime, want.bin, bin_o);
          mismatch_count++;
        end
        if (matched_o !== want.matched) begin
          $display("%0t: matched mismatch, expected %0b, actual %0b",
                   $realtime, want.matched, matched_o);
          mismatch_count++;
        end
        if (dropped_o !== want.dropped) begin
          $display("%0t: dropped mismatch, expected %0b, actual %0b",
                   $realtime, want.dropped, dropped_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    localparam logic [CodeW-1:0] AllSeven = {CodeW{1'b1}};
    localparam logic [CodeW-1:0] Acgt     = 48'h688;
    localparam logic [CodeW-1:0] Tt       = 48'h1B;
    logic        dual;
    logic        keep;
    int unsigned count;
    int unsigned span;
    int          phase;
    int          drain_wait;
    read_item_t  it;

    rst_ni          <= 1'b0;
    start           <= 1'b0;
    mode_i          <= 1'b0;
    entry_i         <= '0;
    first_code_i    <= '0;
    first_length_i  <= '0;
    second_code_i   <= '0;
    second_length_i <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;

    stim_table.push_back(read_row_exp('0, 0, '0, 0, 0, 1'b0, 1'b0));
    stim_table.push_back(read_row_exp(AllSeven, 31, AllSeven, 31, 0, 1'b0, 1'b0));
    stim_table.push_back(load_row(0, Acgt, 4, Tt, 2));
    stim_table.push_back(load_row(1, AllSeven, 16, AllSeven, 31));
    stim_table.push_back(load_row(2, 48'h4, 1, 48'h0, 5));
    stim_table.push_back(load_row(3, 48'hDEAD_BEEF_CAFE, 0, 48'hCAFE_F00D_BEEF, 0));
    stim_table.push_back(settings_row(1'b0, 1'b1, 4));
    stim_table.push_back(read_row(Acgt, 4, '0, 0));
    stim_table.push_back(read_row(Acgt, 3, '0, 0));
    stim_table.push_back(read_row_exp(AllSeven, 16, '0, 0, 1, 1'b1, 1'b0));
    stim_table.push_back(read_row_exp(AllSeven, 31, '0, 0, 1, 1'b1, 1'b0));
    stim_table.push_back(read_row(48'h7FFF_FFFF_FFFF, 16, '0, 0));
    stim_table.push_back(read_row(48'h4, 1, AllSeven, 31));
    stim_table.push_back(settings_row(1'b1, 1'b0, 3));
    stim_table.push_back(read_row(Acgt, 4, Tt, 2));
    stim_table.push_back(read_row_exp(Acgt, 4, Tt, 1, 0, 1'b0, 1'b1));
    stim_table.push_back(read_row(48'h4, 16, 48'h0, 5));
    stim_table.push_back(read_row_exp(48'h4, 16, 48'h8, 5, 0, 1'b0, 1'b1));
    stim_table.push_back(settings_row(1'b0, 1'b0, 0));
    stim_table.push_back(read_row_exp(AllSeven, 16, '0, 0, 0, 1'b0, 1'b1));
    stim_table.push_back(settings_row(1'b1, 1'b1, 0));
    stim_table.push_back(read_row_exp(Acgt, 4, Tt, 2, 0, 1'b0, 1'b0));
    stim_table.push_back(load_row(63, '0, 16, AllSeven, 16));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_SETTINGS) begin
        apply_settings(stim_table[i].dual, stim_table[i].keep, stim_table[i].count);
      end else begin
        drive_item(stim_table[i].item, stim_table[i].has_exp, stim_table[i].exp);
        pace();
      end
    end

    phase = 0;
    while (items_sent < ItemTarget) begin
      dual = 1'($urandom);
      keep = 1'($urandom);
      case ($urandom_range(0, 9))
        0:       count = 0;
        1:       count = NUM_ENTRIES;
        2:       count = $urandom_range(NUM_ENTRIES + 1, 127);
        3:       count = $urandom_range(13, NUM_ENTRIES - 1);
        default: count = $urandom_range(1, 12);
      endcase
      if (phase == 0) begin
        dual  = 1'b1;
        keep  = 1'b0;
        count = NUM_ENTRIES;
      end else if (phase == 1) begin
        dual  = 1'b0;
        keep  = 1'b1;
        count = 127;
      end
      apply_settings(dual, keep, CfgW'(count));
      span = (count > NUM_ENTRIES) ? NUM_ENTRIES : count;
      for (int e = 0; e < span; e++) begin
        if (!tbl_written[e]) begin
          drive_item(random_load(e), 1'b0, '0);
          pace();
        end
      end
      repeat ($urandom_range(60, 160)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: it = random_load($urandom_range(0, NUM_ENTRIES - 1));
          3, 4:    it = random_read();
          default: it = (span == 0) ? random_read() : read_near($urandom_range(0, span - 1));
        endcase
        drive_item(it, 1'b0, '0);
        pace();
      end
      phase++;
    end

    start <= 1'b0;
    drain_wait = 0;
    while (pending_bins.size() != 0 && drain_wait < 4 * Latency) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (Latency + 4) @(posedge clk_i);
    if (pending_bins.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, pending_bins.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bpd_pkg.sv
design/bpd_cell.sv
design/barcode_prefix_demultiplexer.sv
tb/sv/barcode_prefix_demultiplexer_tb.sv
